// ===== rtl/core/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

	// one received byte of a measurement frame
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       first_of_frame;
	} in_req_t;

	// one decoded measurement
	typedef struct packed {
		logic signed [17:0] temperature_scaled;
		logic [16:0]        humidity_scaled;
		logic [1:0]         frame_status;
	} out_req_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
	localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [9:0] SCALE_RESET = 10'd100;

	// byte positions inside a frame
	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	localparam logic [23:0] TEMP_SPAN   = 24'd175;
	localparam logic [22:0] HUM_SPAN    = 23'd100;
	localparam logic [15:0] TEMP_OFFSET = 16'd45;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;
	localparam logic [17:0] TEMP_MAX    = 18'h1FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_RAW,
		ST_SCALE_MUL,
		ST_FOLD_HI,
		ST_FOLD_LO,
		ST_FINISH,
		ST_OUTPUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic scale_raw;
		logic scale_mul;
		logic fold_hi;
		logic fold_lo;
		logic finish;
		logic load_out;
	} htfd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end;
		logic out_free;
	} htfd_stat_t;

	// crc-8, msb first, no final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htfd_ctrl.sv =====
`default_nettype none

module htfd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output htfd_pkg::htfd_cmd_t     cmd,
	input  wire htfd_pkg::htfd_stat_t stat,
	output logic                    ready
);

	htfd_pkg::state_t state_q;
	htfd_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			htfd_pkg::ST_IDLE: begin
				if (in_valid && stat.frame_end) begin
					state_next = htfd_pkg::ST_SCALE_RAW;
				end
			end
			htfd_pkg::ST_SCALE_RAW: state_next = htfd_pkg::ST_SCALE_MUL;
			htfd_pkg::ST_SCALE_MUL: state_next = htfd_pkg::ST_FOLD_HI;
			htfd_pkg::ST_FOLD_HI:   state_next = htfd_pkg::ST_FOLD_LO;
			htfd_pkg::ST_FOLD_LO:   state_next = htfd_pkg::ST_FINISH;
			htfd_pkg::ST_FINISH:    state_next = htfd_pkg::ST_OUTPUT;
			htfd_pkg::ST_OUTPUT: begin
				if (stat.out_free) begin
					state_next = htfd_pkg::ST_IDLE;
				end
			end
			default: state_next = htfd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		unique case (state_q)
			htfd_pkg::ST_IDLE: begin
				ready         = 1'b1;
				cmd.take_byte = in_valid;
			end
			htfd_pkg::ST_SCALE_RAW: cmd.scale_raw = 1'b1;
			htfd_pkg::ST_SCALE_MUL: cmd.scale_mul = 1'b1;
			htfd_pkg::ST_FOLD_HI:   cmd.fold_hi   = 1'b1;
			htfd_pkg::ST_FOLD_LO:   cmd.fold_lo   = 1'b1;
			htfd_pkg::ST_FINISH:    cmd.finish    = 1'b1;
			htfd_pkg::ST_OUTPUT:    cmd.load_out  = stat.out_free;
			default: begin
				ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/htfd_dp.sv =====
`default_nettype none

module htfd_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire htfd_pkg::in_req_t  in_data,
	input  wire htfd_pkg::htfd_cmd_t cmd,
	output htfd_pkg::htfd_stat_t    stat,
	input  wire logic               cfg_wr_en,
	input  wire logic [9:0]         cfg_wr_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output htfd_pkg::out_req_t      out_data
);

	logic [9:0]  scale_q;
	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] raw_t_q;
	logic [15:0] raw_h_q;
	logic        tbad_q;
	logic        hbad_q;

	logic [2:0]  pos_eff;
	logic [7:0]  crc_next;

	// multiply and fold pipeline
	logic [23:0] tmul_s1;
	logic [22:0] hmul_s1;
	logic [15:0] off_s1;
	logic [33:0] tprod_s2;
	logic [32:0] hprod_s2;
	logic [17:0] tq_s3;
	logic [18:0] tr_s3;
	logic [16:0] hq_s3;
	logic [17:0] hr_s3;
	logic [17:0] tq_s4;
	logic [16:0] tr_s4;
	logic [16:0] hq_s4;
	logic [16:0] hr_s4;
	logic [17:0] tq_s5;
	logic        trem_nz_s5;
	logic [16:0] hq_s5;

	logic        out_valid_q;
	htfd_pkg::out_req_t out_q;

	logic        t_neg;
	logic [18:0] t_wide;
	logic [17:0] t_sat;
	htfd_pkg::out_req_t result;

	assign pos_eff  = (in_data.first_of_frame || pos_q > htfd_pkg::POS_HUM_CRC)
		? htfd_pkg::POS_TEMP_HI : pos_q;
	assign crc_next = htfd_pkg::crc8_byte(
		(pos_eff == htfd_pkg::POS_TEMP_HI || pos_eff == htfd_pkg::POS_HUM_HI)
			? htfd_pkg::CRC_INIT : crc_q,
		in_data.rx_byte);

	assign stat.frame_end = (pos_eff == htfd_pkg::POS_HUM_CRC);
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= htfd_pkg::SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// frame capture and crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= htfd_pkg::POS_TEMP_HI;
			crc_q   <= htfd_pkg::CRC_INIT;
			raw_t_q <= '0;
			raw_h_q <= '0;
			tbad_q  <= 1'b0;
			hbad_q  <= 1'b0;
		end else if (cmd.take_byte) begin
			pos_q <= (pos_eff == htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_HI : pos_eff + 3'd1;
			unique case (pos_eff)
				htfd_pkg::POS_TEMP_HI: begin
					crc_q   <= crc_next;
					raw_t_q <= {in_data.rx_byte, 8'd0};
				end
				htfd_pkg::POS_TEMP_LO: begin
					crc_q          <= crc_next;
					raw_t_q[7:0]   <= in_data.rx_byte;
				end
				htfd_pkg::POS_TEMP_CRC: begin
					tbad_q <= (in_data.rx_byte != crc_q);
					crc_q  <= htfd_pkg::CRC_INIT;
				end
				htfd_pkg::POS_HUM_HI: begin
					crc_q   <= crc_next;
					raw_h_q <= {in_data.rx_byte, 8'd0};
				end
				htfd_pkg::POS_HUM_LO: begin
					crc_q        <= crc_next;
					raw_h_q[7:0] <= in_data.rx_byte;
				end
				htfd_pkg::POS_HUM_CRC: begin
					hbad_q <= (in_data.rx_byte != crc_q);
					crc_q  <= htfd_pkg::CRC_INIT;
				end
				default: begin
					crc_q <= crc_q;
				end
			endcase
		end
	end

	// x / 65535 by folding: x = a*2^16 + b gives a*65535 + (a + b)
	always_ff @(posedge clk) begin
		if (cmd.scale_raw) begin
			tmul_s1 <= {8'd0, raw_t_q} * htfd_pkg::TEMP_SPAN;
			hmul_s1 <= {7'd0, raw_h_q} * htfd_pkg::HUM_SPAN;
			off_s1  <= {6'd0, scale_q} * htfd_pkg::TEMP_OFFSET;
		end
		if (cmd.scale_mul) begin
			tprod_s2 <= {10'd0, tmul_s1} * {24'd0, scale_q};
			hprod_s2 <= {10'd0, hmul_s1} * {23'd0, scale_q};
		end
		if (cmd.fold_hi) begin
			tq_s3 <= tprod_s2[33:16];
			tr_s3 <= {3'd0, tprod_s2[15:0]} + {1'b0, tprod_s2[33:16]};
			hq_s3 <= hprod_s2[32:16];
			hr_s3 <= {2'd0, hprod_s2[15:0]} + {1'b0, hprod_s2[32:16]};
		end
		if (cmd.fold_lo) begin
			tq_s4 <= tq_s3 + {15'd0, tr_s3[18:16]};
			tr_s4 <= {1'b0, tr_s3[15:0]} + {14'd0, tr_s3[18:16]};
			hq_s4 <= hq_s3 + {15'd0, hr_s3[17:16]};
			hr_s4 <= {1'b0, hr_s3[15:0]} + {15'd0, hr_s3[17:16]};
		end
		if (cmd.finish) begin
			tq_s5      <= tq_s4 + {17'd0, (tr_s4 >= htfd_pkg::FULL_SCALE)};
			trem_nz_s5 <= (tr_s4 != 17'd0) && (tr_s4 != htfd_pkg::FULL_SCALE);
			hq_s5      <= hq_s4 + {16'd0, (hr_s4 >= htfd_pkg::FULL_SCALE)};
		end
	end

	// negative temperatures truncate toward zero: round the quotient up
	assign t_neg  = ({2'd0, off_s1} > tq_s5);
	assign t_wide = {1'b0, tq_s5} - {3'd0, off_s1} + {18'd0, t_neg && trem_nz_s5};
	assign t_sat  = (!t_wide[18] && t_wide[17]) ? htfd_pkg::TEMP_MAX : t_wide[17:0];

	always_comb begin
		result = '0;
		priority if (tbad_q) begin
			result.frame_status = htfd_pkg::STATUS_TEMP_CRC;
		end else if (hbad_q) begin
			result.frame_status = htfd_pkg::STATUS_HUM_CRC;
		end else begin
			result.frame_status       = htfd_pkg::STATUS_OK;
			result.temperature_scaled = $signed(t_sat);
			result.humidity_scaled    = hq_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
`default_nettype none

// Decodes the six-byte measurement frame of a combined temperature and humidity
// sensor (temp hi, lo, crc, hum hi, lo, crc; crc-8 poly 0x31, init 0xFF) into
// temperature in degrees C and relative humidity in percent, both multiplied by
// scale_factor and truncated toward zero. A crc failure gives zero values and a
// nonzero frame_status (temperature failure takes precedence). first_of_frame on
// a byte restarts the frame and drops any partial one. The sixth byte starts the
// scaling sequence (constant multiply, multiply by scale, two folds of the divide
// by 65535, final correction, output load); the output load also waits for the
// result register to be free. Input stall is high for the whole sequence.
module humidity_temp_frame_decoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// byte requests
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire htfd_pkg::in_req_t in_data,
	// result requests
	output logic               out_valid,
	input  wire logic          out_stall,
	output htfd_pkg::out_req_t out_data,
	// scale_factor register
	input  wire logic          cfg_wr_en,
	input  wire logic [9:0]    cfg_wr_data
);

	htfd_pkg::htfd_cmd_t  cmd;
	htfd_pkg::htfd_stat_t stat;
	logic                 ready;

	// sequencer: byte intake, then the fixed scaling steps
	htfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.stat     (stat),
		.ready    (ready)
	);

	// frame registers, crc, multiply and divide pipeline, result register
	htfd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	// byte requests are taken only while the sequencer is idle
	assign in_stall = !ready;

endmodule

`default_nettype wire

// ===== bench/tb_humidity_temp_frame_decoder.sv =====
module tb_humidity_temp_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import htfd_pkg::*;

	// total byte requests to reach before the random part stops
	localparam int ITEM_TARGET = 1850;
	// cycles to let pass after the last expected reading, covers the scaling sequence
	localparam int SETTLE_CYCLES = 20;

	// conversion constants, signed so the arithmetic stays signed
	localparam longint DEG_SPAN   = 175;
	localparam longint DEG_OFFSET = 45;
	localparam longint RH_SPAN    = 100;
	localparam longint RAW_FULL   = 65535;
	localparam longint DEG_CEIL   = 131071;
	localparam longint DEG_FLOOR  = -131072;

	logic     clk         = 1'b0;
	logic     arst_n      = 1'b0;
	logic     in_valid    = 1'b0;
	in_req_t  in_data     = '0;
	logic     out_stall   = 1'b0;
	logic     cfg_wr_en   = 1'b0;
	logic [9:0] cfg_wr_data = '0;
	logic     in_stall;
	logic     out_valid;
	out_req_t out_data;

	// decoder state as the bench sees it
	logic [2:0]  frame_pos;
	logic [7:0]  crc_run;
	logic [15:0] raw_temp;
	logic [15:0] raw_hum;
	logic        temp_crc_failed;
	logic [9:0]  scale_reg;

	// readings still owed by the block, oldest first
	out_req_t pending_readings[$];

	int  mismatch_count = 0;
	int  bytes_sent     = 0;
	// sender and receiver pacing controls
	bit  tx_quiet       = 1'b0;
	bit  rx_quiet       = 1'b0;
	int  hold_cycles    = 0;

	humidity_temp_frame_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bit-serial crc-8, same result as xor-then-shift over a whole byte
	function automatic logic [7:0] crc_of_byte(input logic [7:0] crc_in, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		$display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// advance the frame by one accepted byte, queue a reading on the sixth
	task automatic decode_byte(input in_req_t req);
		logic     hum_crc_failed;
		out_req_t res;
		longint   s;
		longint   t;
		longint   h;
		if (req.first_of_frame) frame_pos = POS_TEMP_HI;
		// positions past the humidity crc would restart the frame
		if (frame_pos > POS_HUM_CRC) frame_pos = POS_TEMP_HI;
		case (frame_pos)
			POS_TEMP_HI: begin
				crc_run  = crc_of_byte(CRC_INIT, req.rx_byte);
				raw_temp = {req.rx_byte, 8'h00};
			end
			POS_TEMP_LO: begin
				crc_run       = crc_of_byte(crc_run, req.rx_byte);
				raw_temp[7:0] = req.rx_byte;
			end
			POS_TEMP_CRC: begin
				temp_crc_failed = (req.rx_byte != crc_run);
				crc_run         = CRC_INIT;
			end
			POS_HUM_HI: begin
				crc_run = crc_of_byte(CRC_INIT, req.rx_byte);
				raw_hum = {req.rx_byte, 8'h00};
			end
			POS_HUM_LO: begin
				crc_run      = crc_of_byte(crc_run, req.rx_byte);
				raw_hum[7:0] = req.rx_byte;
			end
			default: ;
		endcase
		if (frame_pos != POS_HUM_CRC) begin
			frame_pos = frame_pos + 3'd1;
			return;
		end
		// sixth byte closes the frame
		hum_crc_failed = (req.rx_byte != crc_run);
		crc_run        = CRC_INIT;
		frame_pos      = POS_TEMP_HI;
		t = 0;
		h = 0;
		if (temp_crc_failed) begin
			res.frame_status = STATUS_TEMP_CRC;
		end else if (hum_crc_failed) begin
			res.frame_status = STATUS_HUM_CRC;
		end else begin
			res.frame_status = STATUS_OK;
			s = longint'(scale_reg);
			// signed division truncates toward zero
			t = (DEG_SPAN * longint'(raw_temp) * s - DEG_OFFSET * RAW_FULL * s) / RAW_FULL;
			h = (RH_SPAN * longint'(raw_hum) * s) / RAW_FULL;
			if (t > DEG_CEIL) t = DEG_CEIL;
			if (t < DEG_FLOOR) t = DEG_FLOOR;
		end
		res.temperature_scaled = t[17:0];
		res.humidity_scaled    = h[16:0];
		pending_readings.push_back(res);
	endtask

	// offer one byte request after a random gap, return at the falling edge after it is taken
	task automatic send_byte(input logic [7:0] b, input logic first);
		int      gap;
		in_req_t req;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		req.rx_byte        = b;
		req.first_of_frame = first;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		decode_byte(req);
		bytes_sent++;
		@(negedge clk);
	endtask

	// one whole frame, with either crc optionally spoiled
	task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic first,
	                          input logic bad_t, input logic bad_h);
		logic [7:0] ct;
		logic [7:0] ch;
		ct = crc_of_byte(crc_of_byte(CRC_INIT, t[15:8]), t[7:0]);
		ch = crc_of_byte(crc_of_byte(CRC_INIT, h[15:8]), h[7:0]);
		if (bad_t) ct = ct ^ 8'($urandom_range(1, 255));
		if (bad_h) ch = ch ^ 8'($urandom_range(1, 255));
		send_byte(t[15:8], first);
		send_byte(t[7:0], 1'b0);
		send_byte(ct, 1'b0);
		send_byte(h[15:8], 1'b0);
		send_byte(h[7:0], 1'b0);
		send_byte(ch, 1'b0);
	endtask

	// stop offering and wait until every owed reading has come out
	task automatic drain_readings();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_scale(input logic [9:0] v);
		drain_readings();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scale_reg = v;
	endtask

	function automatic logic [15:0] pick_raw();
		if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic logic [9:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 10'd1;
			1: return 10'd1000;
			2: return ($urandom_range(0, 1) != 0) ? 10'd0 : 10'd1023;
			default: return 10'($urandom_range(1, 1000));
		endcase
	endfunction

	// extremes, every crc outcome, a dropped partial frame, frames without the start flag
	task automatic test_directed_frames();
		// coldest and wettest, then hottest and driest back to back without the flag
		send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
		// both crcs bad, temperature status wins
		send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);
		// partial frame dropped by a restart
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		// humidity crc bad only
		send_frame(16'h1234, 16'hABCD, 1'b1, 1'b0, 1'b1);
		drain_readings();
	endtask

	// scale register across its range, including zero and all ones
	task automatic test_scale_settings();
		logic [9:0] scales[6];
		scales = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd512, 10'd100};
		foreach (scales[i]) begin
			write_scale(scales[i]);
			// at all ones the hottest reading saturates
			send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
			send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
			send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b0);
			send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0);
		end
		drain_readings();
	endtask

	// receiver holds off for a long stretch while the sender keeps pushing frames
	task automatic test_output_backpressure();
		tx_quiet = 1'b1;
		hold_cycles = 400;
		repeat (5) send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0);
		tx_quiet = 1'b0;
		// sender pauses until every reading is back
		drain_readings();
	endtask

	// mostly well-formed frames with random content, some broken frames and stray bytes
	task automatic test_random_traffic();
		int pick;
		int n;
		while (bytes_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(pick_raw(), pick_raw(), 1'($urandom_range(0, 1)),
				           $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12);
			end else if (pick < 80) begin
				// truncated frame, then a flagged restart
				n = $urandom_range(1, 5);
				send_byte(8'($urandom), 1'b1);
				repeat (n - 1) send_byte(8'($urandom), 1'b0);
				send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0);
			end else if (pick < 90) begin
				send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end else if (pick < 97) begin
				// new pacing phase, sometimes with no idling on one side
				tx_quiet = ($urandom_range(0, 2) == 0);
				rx_quiet = ($urandom_range(0, 2) == 0);
			end else begin
				write_scale(pick_scale());
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		drain_readings();
	endtask

	// result side: random hold-off per reading, or a long one when asked
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = rx_quiet ? 0 : $urandom_range(0, 15);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// every accepted reading against the oldest one owed
	always @(posedge clk) begin
		out_req_t want;
		if (out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				flag_mismatch("reading with none owed, status", -1, out_data.frame_status);
			end else begin
				want = pending_readings.pop_front();
				if (out_data.temperature_scaled !== want.temperature_scaled)
					flag_mismatch("temperature_scaled", $signed(want.temperature_scaled),
					              $signed(out_data.temperature_scaled));
				if (out_data.humidity_scaled !== want.humidity_scaled)
					flag_mismatch("humidity_scaled", want.humidity_scaled,
					              out_data.humidity_scaled);
				if (out_data.frame_status !== want.frame_status)
					flag_mismatch("frame_status", want.frame_status, out_data.frame_status);
			end
		end
	end

	// hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		// predictor starts from the reset state
		frame_pos       = POS_TEMP_HI;
		crc_run         = CRC_INIT;
		raw_temp        = '0;
		raw_hum         = '0;
		temp_crc_failed = 1'b0;
		scale_reg       = SCALE_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_scale_settings();
		test_output_backpressure();
		test_random_traffic();

		drain_readings();
		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/htfd_pkg.sv
rtl/core/htfd_ctrl.sv
rtl/core/htfd_dp.sv
rtl/core/humidity_temp_frame_decoder.sv
bench/tb_humidity_temp_frame_decoder.sv
